// File: hdl/pidsc_pkg.sv
// ----------------------------------------------------------------------------
// pidsc_pkg
// shared widths, constants, register codes and payload types of the clamped
// pid speed controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pidsc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ERR_W      = SAMPLE_W + 1;
  localparam int DIFF_W     = SAMPLE_W + 2;
  localparam int SUM_W      = 32;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 15;
  localparam int DUTY_W     = 16;
  localparam int PROD_P_W   = GAIN_W + ERR_W;
  localparam int PROD_I_W   = GAIN_W + SUM_W;
  localparam int PROD_D_W   = GAIN_W + DIFF_W;
  localparam int ACC_W      = PROD_I_W + 2;
  localparam int PROD_SHIFT = 6;
  localparam int CMD_W      = ACC_W - PROD_SHIFT;
  localparam int ROUND_HALF = 32;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int QUEUE_W    = 2;

  localparam logic [LIM_W-1:0] DUTY_ONE = LIM_W'(16384);

  localparam logic signed [GAIN_W-1:0] GAIN_P_RST = GAIN_W'(410);
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST = GAIN_W'(41);
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST = GAIN_W'(82);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_GAIN_P     = 2'd0,
    REG_GAIN_I     = 2'd1,
    REG_GAIN_D     = 2'd2,
    REG_DUTY_LIMIT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] target_speed;
    logic signed [SAMPLE_W-1:0] measured_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [DUTY_W-1:0] duty;
    logic                     clamped;
  } out_item_t;

  // one classified sample: error, difference and saturated running sum
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W-1:0]  sum;
  } work_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [LIM_W-1:0]         duty_limit;
  } cfg_t;

  // back end takes the queue head
  typedef struct packed {
    logic pop;
  } q_ctl_t;

endpackage

// File: hdl/pidsc_front.sv
// ----------------------------------------------------------------------------
// pidsc_front
// takes speed samples, forms error, difference and saturated error sum, and
// keeps the controller state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidsc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pidsc_pkg::in_item_t  in_data,
  input  logic                 q_full,
  output logic                 push,
  output pidsc_pkg::work_t     work
);

  logic signed [pidsc_pkg::ERR_W-1:0] prev_err_r, prev_err_nxt;
  logic signed [pidsc_pkg::SUM_W-1:0] err_sum_r, err_sum_nxt;
  logic signed [pidsc_pkg::ERR_W-1:0] err;
  logic signed [pidsc_pkg::DIFF_W-1:0] diff;
  logic signed [pidsc_pkg::SUM_W:0]   sum_wide;
  logic signed [pidsc_pkg::SUM_W-1:0] sum_sat;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    err  = pidsc_pkg::ERR_W'(in_data.target_speed) - pidsc_pkg::ERR_W'(in_data.measured_speed);
    diff = pidsc_pkg::DIFF_W'(err) - pidsc_pkg::DIFF_W'(prev_err_r);
    sum_wide = (pidsc_pkg::SUM_W+1)'(err_sum_r) + (pidsc_pkg::SUM_W+1)'(err);
    // overflow when the two top bits disagree
    if (sum_wide[pidsc_pkg::SUM_W] != sum_wide[pidsc_pkg::SUM_W-1]) begin
      sum_sat = sum_wide[pidsc_pkg::SUM_W] ? pidsc_pkg::SUM_MIN : pidsc_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_wide[pidsc_pkg::SUM_W-1:0];
    end
    work.err  = err;
    work.diff = diff;
    work.sum  = sum_sat;
    prev_err_nxt = push ? err : prev_err_r;
    err_sum_nxt  = push ? sum_sat : err_sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      err_sum_r  <= '0;
    end else begin
      prev_err_r <= prev_err_nxt;
      err_sum_r  <= err_sum_nxt;
    end
  end

endmodule

// File: hdl/pidsc_queue.sv
// ----------------------------------------------------------------------------
// pidsc_queue
// two-entry queue of classified samples between front and back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidsc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pidsc_pkg::work_t     wr_data,
  output logic                 full,
  input  pidsc_pkg::q_ctl_t    ctl,
  output logic                 q_valid,
  output pidsc_pkg::work_t     rd_data
);

  pidsc_pkg::work_t                  entry_r [pidsc_pkg::QUEUE_W];
  logic                              wr_ptr_r, wr_ptr_nxt;
  logic                              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                        cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'(pidsc_pkg::QUEUE_W));
  assign q_valid = (cnt_r != 2'd0);
  assign rd_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = ctl.pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(pidsc_pkg::QUEUE_W))
    else $error("queue count out of range");

  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !ctl.pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue count did not grow on push");

endmodule

// File: hdl/pidsc_back.sv
// ----------------------------------------------------------------------------
// pidsc_back
// gain multiply, sum and round, clamp; three register stages with stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidsc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pidsc_pkg::cfg_t      cfg,
  input  logic                 q_valid,
  input  pidsc_pkg::work_t     work,
  output pidsc_pkg::q_ctl_t    ctl,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pidsc_pkg::out_item_t out_data
);

  // multiply stage
  logic                                   mul_vld_r, mul_vld_nxt;
  logic signed [pidsc_pkg::PROD_P_W-1:0]  prod_p_r, prod_p_nxt;
  logic signed [pidsc_pkg::PROD_I_W-1:0]  prod_i_r, prod_i_nxt;
  logic signed [pidsc_pkg::PROD_D_W-1:0]  prod_d_r, prod_d_nxt;
  // sum and round stage
  logic                                   cmd_vld_r, cmd_vld_nxt;
  logic signed [pidsc_pkg::CMD_W-1:0]     cmd_r, cmd_nxt;
  logic signed [pidsc_pkg::ACC_W-1:0]     acc;
  // output stage
  logic                                   out_vld_r, out_vld_nxt;
  pidsc_pkg::out_item_t                   out_r, out_nxt;
  logic [pidsc_pkg::LIM_W-1:0]            lim;
  logic signed [pidsc_pkg::CMD_W-1:0]     lim_pos, lim_neg;

  logic adv_out, adv_cmd, adv_mul;

  assign adv_out = !out_vld_r || out_ready;
  assign adv_cmd = !cmd_vld_r || adv_out;
  assign adv_mul = !mul_vld_r || adv_cmd;

  assign ctl.pop   = q_valid && adv_mul;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    prod_p_nxt = prod_p_r;
    prod_i_nxt = prod_i_r;
    prod_d_nxt = prod_d_r;
    mul_vld_nxt = mul_vld_r;
    if (adv_mul) begin
      mul_vld_nxt = q_valid;
      prod_p_nxt  = pidsc_pkg::PROD_P_W'(cfg.gain_p) * pidsc_pkg::PROD_P_W'(work.err);
      prod_i_nxt  = pidsc_pkg::PROD_I_W'(cfg.gain_i) * pidsc_pkg::PROD_I_W'(work.sum);
      prod_d_nxt  = pidsc_pkg::PROD_D_W'(cfg.gain_d) * pidsc_pkg::PROD_D_W'(work.diff);
    end
  end

  always_comb begin
    acc = pidsc_pkg::ACC_W'(prod_p_r) + pidsc_pkg::ACC_W'(prod_i_r)
        + pidsc_pkg::ACC_W'(prod_d_r) + pidsc_pkg::ACC_W'(pidsc_pkg::ROUND_HALF);
    cmd_nxt     = cmd_r;
    cmd_vld_nxt = cmd_vld_r;
    if (adv_cmd) begin
      cmd_vld_nxt = mul_vld_r;
      // floor shift after the half-step bias: round half up
      cmd_nxt     = pidsc_pkg::CMD_W'(acc >>> pidsc_pkg::PROD_SHIFT);
    end
  end

  always_comb begin
    lim     = (cfg.duty_limit > pidsc_pkg::DUTY_ONE) ? pidsc_pkg::DUTY_ONE : cfg.duty_limit;
    lim_pos = pidsc_pkg::CMD_W'(lim);
    lim_neg = -lim_pos;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r;
    if (adv_out) begin
      out_vld_nxt = cmd_vld_r;
      if (cmd_r > lim_pos) begin
        out_nxt.duty    = pidsc_pkg::DUTY_W'(lim_pos);
        out_nxt.clamped = 1'b1;
      end else if (cmd_r < lim_neg) begin
        out_nxt.duty    = pidsc_pkg::DUTY_W'(lim_neg);
        out_nxt.clamped = 1'b1;
      end else begin
        out_nxt.duty    = pidsc_pkg::DUTY_W'(cmd_r);
        out_nxt.clamped = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_p_r <= prod_p_nxt;
    prod_i_r <= prod_i_nxt;
    prod_d_r <= prod_d_nxt;
    cmd_r    <= cmd_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      cmd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= mul_vld_nxt;
      cmd_vld_r <= cmd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.duty <= 16'sd16384 && out_r.duty >= -16'sd16384))
    else $error("duty beyond full scale");

  a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_vld_r && !adv_out) |=> (cmd_vld_r && $stable(cmd_r)))
    else $error("round stage lost a stalled sample");

endmodule

// File: hdl/pid_speed_controller_clamped_unit.sv
// ----------------------------------------------------------------------------
// pid_speed_controller_clamped_unit
// path: input transfer into a queue entry, then queue head into the multiply
// register, round register, clamp into the output register; the path stalls
// while out_ready is low
// throughput: one sample per cycle while out_ready stays high, set by the
// front end updating its state on every transfer; the back end pipeline keeps pace
// reset: synchronous active-low rst_n clears error state, queue and valids,
// and loads the default gains and a duty limit of 1.0
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_speed_controller_clamped_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // sample input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pidsc_pkg::in_item_t              in_data,
  // duty result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output pidsc_pkg::out_item_t             out_data,
  // apb-style register port
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [pidsc_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [pidsc_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [pidsc_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                             cfg_pready
);

  // configuration registers; the user must write them only while the datapath is idle, the block does not enforce it
  logic signed [pidsc_pkg::GAIN_W-1:0] gain_p_r, gain_p_nxt;
  logic signed [pidsc_pkg::GAIN_W-1:0] gain_i_r, gain_i_nxt;
  logic signed [pidsc_pkg::GAIN_W-1:0] gain_d_r, gain_d_nxt;
  logic [pidsc_pkg::LIM_W-1:0]         duty_limit_r, duty_limit_nxt;

  pidsc_pkg::cfg_t     cfg;
  pidsc_pkg::reg_idx_t reg_sel;
  logic                wr_en;

  // front to queue
  logic                q_push;
  logic                q_full;
  pidsc_pkg::work_t    q_wr_data;
  // queue to back
  logic                q_valid;
  pidsc_pkg::work_t    q_rd_data;
  pidsc_pkg::q_ctl_t   q_ctl;

  // register access: word address in bits 3:2, write on the access phase
  assign cfg_pready = 1'b1;
  assign reg_sel    = pidsc_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    gain_p_nxt     = gain_p_r;
    gain_i_nxt     = gain_i_r;
    gain_d_nxt     = gain_d_r;
    duty_limit_nxt = duty_limit_r;
    if (wr_en) begin
      unique case (reg_sel)
        pidsc_pkg::REG_GAIN_P:     gain_p_nxt     = cfg_pwdata[pidsc_pkg::GAIN_W-1:0];
        pidsc_pkg::REG_GAIN_I:     gain_i_nxt     = cfg_pwdata[pidsc_pkg::GAIN_W-1:0];
        pidsc_pkg::REG_GAIN_D:     gain_d_nxt     = cfg_pwdata[pidsc_pkg::GAIN_W-1:0];
        pidsc_pkg::REG_DUTY_LIMIT: duty_limit_nxt = cfg_pwdata[pidsc_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // read back the raw register contents, zero extended
  always_comb begin
    unique case (reg_sel)
      pidsc_pkg::REG_GAIN_P:     cfg_prdata = pidsc_pkg::DATA_W'(unsigned'(gain_p_r));
      pidsc_pkg::REG_GAIN_I:     cfg_prdata = pidsc_pkg::DATA_W'(unsigned'(gain_i_r));
      pidsc_pkg::REG_GAIN_D:     cfg_prdata = pidsc_pkg::DATA_W'(unsigned'(gain_d_r));
      pidsc_pkg::REG_DUTY_LIMIT: cfg_prdata = pidsc_pkg::DATA_W'(duty_limit_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= pidsc_pkg::GAIN_P_RST;
      gain_i_r     <= pidsc_pkg::GAIN_I_RST;
      gain_d_r     <= pidsc_pkg::GAIN_D_RST;
      duty_limit_r <= pidsc_pkg::DUTY_ONE;
    end else begin
      gain_p_r     <= gain_p_nxt;
      gain_i_r     <= gain_i_nxt;
      gain_d_r     <= gain_d_nxt;
      duty_limit_r <= duty_limit_nxt;
    end
  end

  assign cfg.gain_p     = gain_p_r;
  assign cfg.gain_i     = gain_i_r;
  assign cfg.gain_d     = gain_d_r;
  assign cfg.duty_limit = duty_limit_r;

  // front end: takes each transfer and advances the error state at once
  pidsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (q_push),
    .work     (q_wr_data)
  );

  // short queue decouples input from a stalled result side
  pidsc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .ctl      (q_ctl),
    .q_valid  (q_valid),
    .rd_data  (q_rd_data)
  );

  // back end: gains, rounding to q1.14, clamp, output register
  pidsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .work      (q_rd_data),
    .ctl       (q_ctl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: tb/tb_pid_speed_controller_clamped_unit.sv
// ----------------------------------------------------------------------------
// tb_pid_speed_controller_clamped_unit
// self-checking bench for the clamped pid speed controller: a directed table
// of corner samples and register settings, then random phases under changing
// gains, limits and handshake pressure. every duty result is checked against
// a typed value or a cycle-free control law model tracking accepted samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pid_speed_controller_clamped_unit;

  // run guard, far above the slowest correct run
  localparam int CYCLE_LIMIT   = 100_000;
  localparam int PHASE_SAMPLES = 169;
  localparam int RAND_PHASES   = 8;

  typedef enum logic {ROW_REGS, ROW_SAMPLE} row_kind_t;

  // one directed step: either a full register load or one speed sample,
  // optionally with the duty result typed in by hand
  typedef struct {
    row_kind_t            kind;
    pidsc_pkg::cfg_t      regs;
    pidsc_pkg::in_item_t  smp;
    bit                   known;
    pidsc_pkg::out_item_t want;
  } plan_row_t;

  // dut ports, all inputs known from time zero
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  pidsc_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pidsc_pkg::out_item_t out_data;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [pidsc_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [pidsc_pkg::DATA_W-1:0] cfg_pwdata = '0;
  logic [pidsc_pkg::DATA_W-1:0] cfg_prdata;
  logic                 cfg_pready;

  // controller model state and its copy of the registers
  logic signed [pidsc_pkg::ERR_W-1:0] ctl_prev_err;
  logic signed [pidsc_pkg::SUM_W-1:0] ctl_err_sum;
  pidsc_pkg::cfg_t                    ctl_cfg;

  // duty results still owed by the dut, oldest first
  pidsc_pkg::out_item_t duty_q [$];

  int gap_pct = 0;
  int stall_pct = 0;
  int fails = 0;
  int cycles = 0;
  pidsc_pkg::out_item_t head;

  pid_speed_controller_clamped_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop if the pipeline ever hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side back-pressure, redrawn every cycle at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // control law: error, difference, saturating sum, weighted sum of the three
  // terms, round half up from q.20 to q1.14, then symmetric clamp
  // ---------------------------------------------------------------------------
  function automatic pidsc_pkg::out_item_t step_pid(input pidsc_pkg::in_item_t s);
    longint err, diff, sum, acc, cmd, lim;
    pidsc_pkg::out_item_t r;
    err  = longint'($signed(s.target_speed)) - longint'($signed(s.measured_speed));
    diff = err - longint'(ctl_prev_err);
    sum  = longint'(ctl_err_sum) + err;
    // the running sum sticks at the rails instead of wrapping
    if (sum > longint'(pidsc_pkg::SUM_MAX)) sum = longint'(pidsc_pkg::SUM_MAX);
    if (sum < longint'(pidsc_pkg::SUM_MIN)) sum = longint'(pidsc_pkg::SUM_MIN);
    ctl_err_sum  = pidsc_pkg::SUM_W'(sum);
    ctl_prev_err = pidsc_pkg::ERR_W'(err);
    acc = longint'($signed(ctl_cfg.gain_p)) * err
        + longint'($signed(ctl_cfg.gain_i)) * sum
        + longint'($signed(ctl_cfg.gain_d)) * diff;
    // arithmetic shift floors, so adding half first gives round half up
    cmd = (acc + pidsc_pkg::ROUND_HALF) >>> pidsc_pkg::PROD_SHIFT;
    // a limit programmed above 1.0 acts as 1.0
    lim = (ctl_cfg.duty_limit > pidsc_pkg::DUTY_ONE) ? longint'(pidsc_pkg::DUTY_ONE)
                                                      : longint'(ctl_cfg.duty_limit);
    r.clamped = 1'b0;
    // a command sitting exactly on the limit is not flagged
    if (cmd > lim) begin
      cmd = lim;
      r.clamped = 1'b1;
    end else if (cmd < -lim) begin
      cmd = -lim;
      r.clamped = 1'b1;
    end
    r.duty = pidsc_pkg::DUTY_W'(cmd);
    return r;
  endfunction

  function automatic pidsc_pkg::cfg_t mk_cfg(input int gp, input int gi, input int gd,
                                             input int lim);
    pidsc_pkg::cfg_t c;
    c.gain_p     = pidsc_pkg::GAIN_W'(gp);
    c.gain_i     = pidsc_pkg::GAIN_W'(gi);
    c.gain_d     = pidsc_pkg::GAIN_W'(gd);
    c.duty_limit = pidsc_pkg::LIM_W'(lim);
    return c;
  endfunction

  function automatic plan_row_t regs_row(input int gp, input int gi, input int gd,
                                         input int lim);
    plan_row_t r;
    r = '{kind: ROW_REGS, regs: mk_cfg(gp, gi, gd, lim), smp: '0, known: 1'b0, want: '0};
    return r;
  endfunction

  function automatic plan_row_t smp_row(input int t, input int m);
    plan_row_t r;
    r = '{kind: ROW_SAMPLE, regs: '0, smp: '0, known: 1'b0, want: '0};
    r.smp.target_speed   = pidsc_pkg::SAMPLE_W'(t);
    r.smp.measured_speed = pidsc_pkg::SAMPLE_W'(m);
    return r;
  endfunction

  function automatic plan_row_t known_row(input int t, input int m, input int duty,
                                          input bit clamp);
    plan_row_t r;
    r = smp_row(t, m);
    r.known        = 1'b1;
    r.want.duty    = pidsc_pkg::DUTY_W'(duty);
    r.want.clamped = clamp;
    return r;
  endfunction

  // gains lean toward small values so the output is not pinned at the rails
  function automatic int rand_gain();
    case ($urandom_range(7)) inside
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      [3:5]:   return int'($urandom_range(1200)) - 600;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic int rand_limit();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 1;
      2:       return 16384;
      3:       return 32767;
      4:       return int'($urandom_range(32767));
      default: return int'($urandom_range(16384));
    endcase
  endfunction

  // mostly a speed loop near its target, with some wild samples and rail hits
  function automatic pidsc_pkg::in_item_t rand_sample();
    pidsc_pkg::in_item_t s;
    s.target_speed = pidsc_pkg::SAMPLE_W'($urandom);
    case ($urandom_range(15))
      0:       s.measured_speed = pidsc_pkg::SAMPLE_W'($urandom);
      1: begin
        s.target_speed   = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        s.measured_speed = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      end
      default: s.measured_speed = s.target_speed
                                + pidsc_pkg::SAMPLE_W'(int'($urandom_range(512)) - 256);
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // sample transfer: optional idle cycles, then hold valid until accepted.
  // entered and left at a falling edge; valid stays high for a follow-on
  // ---------------------------------------------------------------------------
  task automatic push_sample(input pidsc_pkg::in_item_t s, input bit known,
                             input pidsc_pkg::out_item_t want);
    pidsc_pkg::out_item_t pred;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    // model advances on every accepted sample, typed rows included
    pred = step_pid(s);
    duty_q.push_back(known ? want : pred);
    @(negedge clk);
  endtask

  // one apb write, setup then access; returns on the edge that writes it
  task automatic apb_write(input pidsc_pkg::reg_idx_t idx, input logic [15:0] value);
    logic [pidsc_pkg::DATA_W-1:0] word;
    word = $urandom;
    word[15:0] = value;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= pidsc_pkg::ADDR_W'(4 * int'(idx));
    cfg_pwdata  <= word;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  // full register load, only once the pipeline has drained
  task automatic load_regs(input pidsc_pkg::cfg_t c);
    while (duty_q.size() != 0) @(negedge clk);
    apb_write(pidsc_pkg::REG_GAIN_P, c.gain_p);
    @(negedge clk);
    apb_write(pidsc_pkg::REG_GAIN_I, c.gain_i);
    @(negedge clk);
    apb_write(pidsc_pkg::REG_GAIN_D, c.gain_d);
    @(negedge clk);
    apb_write(pidsc_pkg::REG_DUTY_LIMIT, {1'b0, c.duty_limit});
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    ctl_cfg = c;
  endtask

  // ---------------------------------------------------------------------------
  // result checker, in order against the oldest owed result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (duty_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, got duty=%0d clamped=%0b",
                 $time, $signed(out_data.duty), out_data.clamped);
        fails++;
      end else begin
        head = duty_q.pop_front();
        if (out_data.duty !== head.duty || out_data.clamped !== head.clamped) begin
          $display("%0t: mismatch, expected duty=%0d clamped=%0b, got duty=%0d clamped=%0b",
                   $time, $signed(head.duty), head.clamped,
                   $signed(out_data.duty), out_data.clamped);
          fails++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t plan [$];
    int        gaps [4];
    int        stalls [4];

    // idle profiles: none, sender gaps, receiver stalls, both
    gaps   = '{0, 72, 0, 35};
    stalls = '{0, 0, 72, 35};

    plan = {
      // reset defaults: zero error, then both error rails
      known_row(0, 0, 0, 1'b0),
      known_row(32767, -32768, 16384, 1'b1),
      known_row(-32768, 32767, -16384, 1'b1),
      smp_row(1234, -567),
      smp_row(-1, 1),
      // unit p gain only: duty is the error rounded half up over 64
      regs_row(1, 0, 0, 16384),
      known_row(32, 0, 1, 1'b0),
      known_row(0, 32, 0, 1'b0),
      known_row(-33, 0, -1, 1'b0),
      known_row(31, 0, 0, 1'b0),
      known_row(96, 0, 2, 1'b0),
      // limit of one lsb: exactly on the limit passes unflagged
      regs_row(1, 0, 0, 1),
      known_row(32, 0, 1, 1'b0),
      known_row(0, 33, -1, 1'b0),
      known_row(96, 0, 1, 1'b1),
      known_row(0, 97, -1, 1'b1),
      // zero limit: flag set for any nonzero command
      regs_row(1, 0, 0, 0),
      known_row(0, 0, 0, 1'b0),
      known_row(31, 0, 0, 1'b0),
      known_row(32, 0, 0, 1'b1),
      known_row(0, 33, 0, 1'b1),
      // limit above 1.0 behaves as 1.0, max positive gain
      regs_row(32767, 0, 0, 32767),
      known_row(32767, -32768, 16384, 1'b1),
      smp_row(0, 1),
      // most negative gains on every term
      regs_row(-32768, -32768, -32768, 16384),
      smp_row(-32768, 32767),
      smp_row(12345, 23456)
    };

    // model matches the reset state
    ctl_prev_err = '0;
    ctl_err_sum  = '0;
    ctl_cfg      = '{gain_p: pidsc_pkg::GAIN_P_RST, gain_i: pidsc_pkg::GAIN_I_RST,
                     gain_d: pidsc_pkg::GAIN_D_RST, duty_limit: pidsc_pkg::DUTY_ONE};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REGS) begin
        in_valid <= 1'b0;
        load_regs(plan[i].regs);
      end else begin
        push_sample(plan[i].smp, plan[i].known, plan[i].want);
      end
    end

    // random phases, each with fresh registers and its own idle profile
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      in_valid <= 1'b0;
      load_regs(mk_cfg(rand_gain(), rand_gain(), rand_gain(), rand_limit()));
      gap_pct   = gaps[ph % 4];
      stall_pct = stalls[ph % 4];
      repeat (PHASE_SAMPLES) push_sample(rand_sample(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain, then keep watching for stray transfers
    while (duty_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
